@@ hw/rtl/lcs_pkg.sv @@
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types for the LCS length row engine: the beat that walks the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package lcs_pkg;

  // one beat as it travels from cell to cell
  typedef struct packed {
    logic       valid;     // slot holds a beat
    logic       is_query;  // 1 = query character, 0 = reference character
    logic       last;      // final character of its string
    logic       clear;     // reference beat that starts a new reference
    logic       wr;        // reference beat that stores its character
    logic       ovf;       // truncation flag carried by a query beat
    logic [7:0] ch;        // character byte
  } beat_t;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned LenWidth   = 9;
  localparam int unsigned OutDataPad = 16;

endpackage

`default_nettype wire

@@ hw/rtl/lcs_cell.sv @@
// ----------------------------------------------------------------------------
// lcs_cell
// One column of the score row: holds a reference character and its score,
// updates on each passing query beat while active and hands the beat on through its beat register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 8,
  parameter int unsigned SW  = 9
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire lcs_pkg::beat_t        in_beat,
  input  wire logic [IW-1:0]         in_idx,
  input  wire logic [SW-1:0]         in_left,
  input  wire logic [SW-1:0]         in_diag,
  output lcs_pkg::beat_t             out_beat,
  output logic      [IW-1:0]         out_idx,
  output logic      [SW-1:0]         out_left,
  output logic      [SW-1:0]         out_diag
);
  import lcs_pkg::*;

  logic [CharWidth-1:0] ref_char_r;
  logic                 active_r;
  logic [SW-1:0]        score_r;
  logic [SW-1:0]        score_nxt;
  logic                 active_nxt;
  logic [SW-1:0]        cell_val;
  logic                 match;
  logic                 hit;
  beat_t                beat_r;
  logic [IW-1:0]        idx_r;
  logic [SW-1:0]        left_r;
  logic [SW-1:0]        diag_r;

  // dp recurrence for this column
  assign match    = (ref_char_r == in_beat.ch);
  assign cell_val = match ? (in_diag + SW'(1)) : ((score_r > in_left) ? score_r : in_left);
  assign hit      = in_beat.wr && (in_idx == IW'(IDX));

  // next state of the column
  always_comb begin
    score_nxt  = score_r;
    active_nxt = active_r;
    if (in_beat.valid) begin
      if (in_beat.is_query) begin
        if (active_r) begin
          score_nxt = in_beat.last ? '0 : cell_val;
        end
      end else begin
        if (in_beat.clear) begin
          score_nxt  = '0;
          active_nxt = 1'b0;
        end
        if (hit) begin
          active_nxt = 1'b1;
        end
      end
    end
  end

  // column state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      score_r  <= '0;
    end else if (adv) begin
      active_r <= active_nxt;
      score_r  <= score_nxt;
    end
  end

  // reference character store
  always_ff @(posedge clk) begin
    if (adv && in_beat.valid && !in_beat.is_query && hit) begin
      ref_char_r <= in_beat.ch;
    end
  end

  // hand the beat to the next column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else if (adv) begin
      beat_r <= in_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_r  <= in_idx;
      left_r <= (active_r && in_beat.is_query) ? cell_val : in_left;
      diag_r <= score_r;
    end
  end

  assign out_beat = beat_r;
  assign out_idx  = idx_r;
  assign out_left = left_r;
  assign out_diag = diag_r;

endmodule

`default_nettype wire

@@ hw/rtl/lcs_entry.sv @@
// ----------------------------------------------------------------------------
// lcs_entry
// Reference bookkeeping at the head of the chain: length, completion and
// truncation; turns an input beat into a chain beat or drops it.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_entry #(
  parameter int unsigned MAX_LEN = 256,
  parameter int unsigned IW      = 8,
  parameter int unsigned LW      = 9
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       take,
  input  wire logic                       kind,
  input  wire logic [lcs_pkg::CharWidth-1:0] ch,
  input  wire logic                       last,
  output lcs_pkg::beat_t                  beat,
  output logic      [IW-1:0]              idx
);
  import lcs_pkg::*;

  logic [LW-1:0] ref_len_r;
  logic [LW-1:0] ref_len_nxt;
  logic          ref_done_r;
  logic          ref_done_nxt;
  logic          ovf_r;
  logic          ovf_nxt;
  logic          start;
  logic [LW-1:0] len_base;
  logic          room;

  // a reference beat after a completed reference opens a new one
  assign start    = ref_done_r;
  assign len_base = start ? '0 : ref_len_r;
  assign room     = (len_base < LW'(MAX_LEN));

  always_comb begin
    ref_len_nxt  = ref_len_r;
    ref_done_nxt = ref_done_r;
    ovf_nxt      = ovf_r;
    if (take && !kind) begin
      ref_len_nxt  = room ? (len_base + LW'(1)) : len_base;
      ref_done_nxt = last;
      ovf_nxt      = (start ? 1'b0 : ovf_r) | !room;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_len_r  <= '0;
      ref_done_r <= 1'b0;
      ovf_r      <= 1'b0;
    end else begin
      ref_len_r  <= ref_len_nxt;
      ref_done_r <= ref_done_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // beat for the first column; early queries become bubbles
  always_comb begin
    beat.valid    = take && (!kind || ref_done_r);
    beat.is_query = kind;
    beat.last     = last;
    beat.clear    = !kind && start;
    beat.wr       = !kind && room;
    beat.ovf      = ovf_r;
    beat.ch       = ch;
  end

  assign idx = len_base[IW-1:0];

  // length never passes the row size
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ref_len_r <= LW'(MAX_LEN))
    else $error("reference length beyond row size");

  // a completed reference holds at least one character
  a_done_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ref_done_r |-> (ref_len_r != '0))
    else $error("completed reference is empty");

endmodule

`default_nettype wire

@@ hw/rtl/lcs_length_row_engine.sv @@
// ----------------------------------------------------------------------------
// lcs_length_row_engine
// LCS length of a stored reference string against query strings, computed
// by a systolic row of cells, one cell per reference character.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  in_      | in  | tdata[7:0] char_value, tuser kind, tlast last_char
//  out_     | out | tdata[8:0] lcs_length (zero padded to 16), tuser too_long
//
//  one beat is accepted per cycle while the output is not stalled; each beat
//  walks the chain of MAX_LEN cells, one cell a cycle while the chain moves,
//  through the beat register of every cell and then the output register
//  output backpressure freezes the whole chain and drops in_tready
//  synchronous reset clears all scores at once; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_length_row_engine #(
  parameter int unsigned MAX_LEN = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_value
  input  wire logic        in_tuser,   // [0] kind
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [8:0] lcs_length, [15:9] zero
  output logic             out_tuser   // [0] too_long
);
  import lcs_pkg::*;

  localparam int unsigned IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned SW = LW;

  beat_t         beat_w [MAX_LEN+1];
  logic [IW-1:0] idx_w  [MAX_LEN+1];
  logic [SW-1:0] left_w [MAX_LEN+1];
  logic [SW-1:0] diag_w [MAX_LEN+1];

  logic                adv;
  logic                take;
  logic                out_valid_r;
  logic [LenWidth-1:0] lcs_r;
  logic                too_long_r;
  logic                res_hit;
  logic [LenWidth-1:0] lcs_sat;
  beat_t               end_beat;
  logic [SW-1:0]       end_left;

  // chain moves whenever the output slot is free or draining
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign take      = in_tvalid && adv;

  lcs_entry #(
    .MAX_LEN (MAX_LEN),
    .IW      (IW),
    .LW      (LW)
  ) u_entry (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .kind  (in_tuser),
    .ch    (in_tdata),
    .last  (in_tlast),
    .beat  (beat_w[0]),
    .idx   (idx_w[0])
  );

  assign left_w[0] = '0;
  assign diag_w[0] = '0;

  // row of cells
  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    lcs_cell #(
      .IDX (g),
      .IW  (IW),
      .SW  (SW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_beat  (beat_w[g]),
      .in_idx   (idx_w[g]),
      .in_left  (left_w[g]),
      .in_diag  (diag_w[g]),
      .out_beat (beat_w[g+1]),
      .out_idx  (idx_w[g+1]),
      .out_left (left_w[g+1]),
      .out_diag (diag_w[g+1])
    );
  end

  assign end_beat = beat_w[MAX_LEN];
  assign end_left = left_w[MAX_LEN];

  // last query beat leaving the chain carries the final column score
  assign res_hit = end_beat.valid && end_beat.is_query && end_beat.last;
  assign lcs_sat = (32'(end_left) > 32'd511) ? 9'd511 : LenWidth'(end_left);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_hit) begin
      lcs_r      <= lcs_sat;
      too_long_r <= end_beat.ovf;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OutDataPad - LenWidth)'(0), lcs_r};
  assign out_tuser  = too_long_r;

  // a result only follows a last query beat at the chain end
  a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(res_hit))
    else $error("result without a last query beat");

  // a waiting result blocks new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while result stalled");

  // a frozen chain keeps its end beat
  a_chain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && $past(rst_n)) |=> $stable(end_beat))
    else $error("chain moved during stall");

endmodule

`default_nettype wire

@@ verif/tb_lcs_length_row_engine.sv @@
// ----------------------------------------------------------------------------
// tb_lcs_length_row_engine
// Self-checking bench for the LCS length row engine. Reference and query
// strings are streamed in over the input channel with bursty timing while the
// result channel stalls on its own pattern. A scoreboard keeps its own copy of
// the stored reference and the score row, predicts each score and truncation
// flag, and compares every result beat in order.
// ----------------------------------------------------------------------------
module tb_lcs_length_row_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REF_CELLS   = 256;
  localparam int unsigned DRAIN_WAIT  = REF_CELLS + 64;
  localparam int unsigned RAND_BEATS  = 850;
  localparam int unsigned MAX_PRINTS  = 40;
  localparam int unsigned SCORE_MAX   = (1 << lcs_pkg::LenWidth) - 1;

  // receiver stall modes
  localparam int unsigned RX_FREE = 0;
  localparam int unsigned RX_COIN = 1;
  localparam int unsigned RX_SLOW = 2;

  typedef enum bit {
    KIND_REF   = 1'b0,
    KIND_QUERY = 1'b1
  } char_kind_e;

  typedef struct {
    bit [lcs_pkg::LenWidth-1:0] lcs_length;
    bit                         too_long;
  } lcs_result_t;

  // scoreboard: mirrors the stored reference and the score row
  class lcs_scoreboard;
    bit [7:0]    ref_chars [REF_CELLS];
    int unsigned row_scores [REF_CELLS];
    int unsigned ref_len;
    bit          ref_done;
    bit          truncated;
    lcs_result_t pending_scores [$];
    int unsigned errors;

    function new();
      ref_len   = 0;
      ref_done  = 1'b0;
      truncated = 1'b0;
      errors    = 0;
      clear_row();
    endfunction

    function void clear_row();
      foreach (row_scores[j]) row_scores[j] = 0;
    endfunction

    function int unsigned pending();
      return pending_scores.size();
    endfunction

    // one accepted input beat
    function void note_input(bit kind, bit [7:0] ch, bit last);
      int unsigned diag;
      int unsigned left;
      int unsigned up;
      int unsigned col_score;
      bit [31:0]   final_score;
      lcs_result_t res;
      if (kind == KIND_REF) begin
        // first character after a finished reference starts a new one
        if (ref_done) begin
          ref_len   = 0;
          ref_done  = 1'b0;
          truncated = 1'b0;
          clear_row();
        end
        if (ref_len < REF_CELLS) begin
          ref_chars[ref_len] = ch;
          ref_len++;
        end else begin
          truncated = 1'b1;
        end
        if (last) ref_done = 1'b1;
        return;
      end
      // query characters are dropped until the reference is complete
      if (!ref_done || ref_len == 0) return;
      diag = 0;
      left = 0;
      for (int unsigned j = 0; j < ref_len; j++) begin
        up = row_scores[j];
        if (ref_chars[j] == ch) col_score = diag + 1;
        else col_score = (up > left) ? up : left;
        diag          = up;
        row_scores[j] = col_score;
        left          = col_score;
      end
      if (!last) return;
      final_score    = (row_scores[ref_len-1] > SCORE_MAX) ? SCORE_MAX : row_scores[ref_len-1];
      res.lcs_length = final_score[lcs_pkg::LenWidth-1:0];
      res.too_long   = truncated;
      pending_scores.push_back(res);
      clear_row();
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] error: %s", $time, what);
    endtask

    // one accepted result beat
    task check_result(logic [15:0] tdata, logic tuser);
      lcs_result_t want;
      if (pending_scores.size() == 0) begin
        report($sformatf("unexpected result len=%0d too_long=%b", tdata[8:0], tuser));
        return;
      end
      want = pending_scores.pop_front();
      if (tdata[lcs_pkg::LenWidth-1:0] !== want.lcs_length)
        report($sformatf("lcs_length got %0d want %0d", tdata[8:0], want.lcs_length));
      if (tdata[lcs_pkg::OutDataPad-1:lcs_pkg::LenWidth] !== '0)
        report($sformatf("tdata pad bits not zero: %h", tdata));
      if (tuser !== want.too_long)
        report($sformatf("too_long got %b want %b", tuser, want.too_long));
    endtask
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [7:0] char_value
  logic        in_tuser   = 1'b0; // [0] kind
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [8:0] lcs_length, [15:9] zero
  logic        out_tuser;         // [0] too_long

  lcs_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned beats_sent = 0;
  int unsigned rx_mode    = RX_FREE;
  int unsigned rx_left    = 0;

  lcs_length_row_engine #(
    .MAX_LEN(REF_CELLS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver ready pattern: stretches of free flow, coin flips and heavy stall
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      if (rx_mode > RX_SLOW) rx_mode = RX_FREE;
      rx_left = $urandom_range(20, 300);
    end
    rx_left--;
    case (rx_mode)
      RX_COIN: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      RX_SLOW: begin
        out_tready <= ($urandom_range(0, 5) == 0);
      end
      default: begin
        out_tready <= 1'b1;
      end
    endcase
  end

  // beat monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata, in_tlast);
    end
  end

  // send one beat, with bursts and random gaps between them
  task automatic send_beat(input char_kind_e kind, input bit [7:0] ch, input bit last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= ch;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  // hold off the sender until every predicted score has come back
  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic bit [7:0] pick_char(bit [7:0] base, int unsigned alph);
    return base + 8'($urandom_range(0, alph - 1));
  endfunction

  // full-length reference of one repeated character, matched all the way
  task automatic run_full_match();
    bit [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    for (int unsigned i = 0; i < REF_CELLS; i++) send_beat(KIND_REF, ch, i == REF_CELLS - 1);
    for (int unsigned i = 0; i < REF_CELLS; i++) send_beat(KIND_QUERY, ch, i == REF_CELLS - 1);
  endtask

  // one reference followed by a few queries against it
  task automatic run_session();
    int unsigned ref_len;
    int unsigned alph;
    int unsigned n_queries;
    int unsigned q_len;
    int unsigned pick;
    bit [7:0]    base;
    bit          hang;
    pick = $urandom_range(0, 99);
    if (pick < 84) ref_len = $urandom_range(1, 16);
    else if (pick < 94) ref_len = $urandom_range(REF_CELLS - 16, REF_CELLS);
    else ref_len = $urandom_range(REF_CELLS + 1, REF_CELLS + 16);
    alph = ($urandom_range(0, 9) < 3) ? 256 : $urandom_range(1, 4);
    base = 8'($urandom_range(0, 255));

    // reference load, now and then a stray query that must be dropped
    for (int unsigned i = 0; i < ref_len; i++) begin
      if (i != 0 && $urandom_range(0, 19) == 0)
        send_beat(KIND_QUERY, pick_char(base, alph), 1'($urandom_range(0, 1)));
      send_beat(KIND_REF, pick_char(base, alph), i == ref_len - 1);
    end

    // queries; occasionally a query is left without its last beat
    n_queries = $urandom_range(1, 4);
    for (int unsigned k = 0; k < n_queries; k++) begin
      q_len = $urandom_range(1, (ref_len > 16) ? 24 : 16);
      hang  = ($urandom_range(0, 11) == 0);
      for (int unsigned i = 0; i < q_len; i++)
        send_beat(KIND_QUERY, pick_char(base, alph), (i == q_len - 1) && !hang);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: query before any reference, query during a reference load
    send_beat(KIND_QUERY, 8'h58, 1'b1);
    send_beat(KIND_REF,   8'h00, 1'b0);
    send_beat(KIND_QUERY, 8'h00, 1'b1);
    send_beat(KIND_REF,   8'hFF, 1'b1);
    // character extremes in both orders, then a miss
    send_beat(KIND_QUERY, 8'hFF, 1'b0);
    send_beat(KIND_QUERY, 8'h00, 1'b1);
    send_beat(KIND_QUERY, 8'h00, 1'b0);
    send_beat(KIND_QUERY, 8'hFF, 1'b1);
    send_beat(KIND_QUERY, 8'h55, 1'b1);
    // single-character reference, repeated query characters
    send_beat(KIND_REF,   8'hAA, 1'b1);
    send_beat(KIND_QUERY, 8'hAA, 1'b1);
    send_beat(KIND_QUERY, 8'hAA, 1'b0);
    send_beat(KIND_QUERY, 8'hAA, 1'b1);
    // unfinished query, then a new reference must clear the row
    send_beat(KIND_QUERY, 8'h41, 1'b0);
    send_beat(KIND_REF,   8'h41, 1'b1);
    send_beat(KIND_QUERY, 8'h41, 1'b1);
    // mixed strings
    send_beat(KIND_REF,   8'h41, 1'b0);
    send_beat(KIND_REF,   8'h42, 1'b0);
    send_beat(KIND_REF,   8'h43, 1'b0);
    send_beat(KIND_REF,   8'h42, 1'b0);
    send_beat(KIND_REF,   8'h44, 1'b1);
    send_beat(KIND_QUERY, 8'h42, 1'b0);
    send_beat(KIND_QUERY, 8'h44, 1'b0);
    send_beat(KIND_QUERY, 8'h43, 1'b0);
    send_beat(KIND_QUERY, 8'h41, 1'b0);
    send_beat(KIND_QUERY, 8'h42, 1'b1);
    pause_until_drained();

    // random part
    run_full_match();
    while (beats_sent < RAND_BEATS) begin
      run_session();
      if ($urandom_range(0, 29) == 0) pause_until_drained();
    end

    // drain and settle
    pause_until_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("lcs_length_row_engine: match");
    end else begin
      $display("lcs_length_row_engine: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("lcs_length_row_engine: mismatch");
    $finish;
  end

endmodule
